FILE: sv/emr_pkg.sv
package emr_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = COL_W + 1;
    localparam int PICK_W      = 8;
    localparam int CFG_W       = 5;
    localparam int JOIN_W      = MAX_COLUMNS - 1;

    // row sequencer phases, seen by every cell
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_JOIN,
        ST_COUNT,
        ST_KCALC,
        ST_PICK,
        ST_DONE
    } t_state;

    // per-row control broadcast from the sequencer to the cells
    typedef struct packed {
        t_state              st;
        logic                init;
        logic                commit;
        logic                in_first;
        logic                in_last;
        logic                last;
        logic [PICK_W-1:0]   pick;
    } t_ctl;

    // shared row bus, driven only by the cell holding the token
    typedef struct packed {
        logic                act;
        logic                car;
        logic [COL_W-1:0]    lab;
        logic [COL_W-1:0]    idx;
        logic                merge;
        logic [COL_W-1:0]    lo;
        logic [COL_W-1:0]    hi;
        logic                opn;
    } t_bus;

endpackage

FILE: sv/emr_cell.sv
module emr_cell
    import emr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [COL_W-1:0] i_col,
    input  logic             i_use,
    input  t_ctl             i_ctl,
    input  logic             i_jbit,
    input  logic             i_obit,
    input  logic             i_tok,
    output logic             o_tok,
    input  logic [COL_W-1:0] i_right_lab,
    output logic [COL_W-1:0] o_lab,
    input  t_bus             i_bus,
    output t_bus             o_bus,
    input  logic             i_hit,
    output logic             o_hit,
    output logic             o_wall,
    output logic             o_open
);

    logic                    r_tok;
    logic [COL_W-1:0]        r_lab, n_lab;
    logic                    r_car, n_car;
    logic [COL_W-1:0]        r_raw, n_raw;
    logic                    r_rcar, n_rcar;
    logic                    r_asg, n_asg;
    logic                    r_jb, n_jb;
    logic                    r_opn, n_opn;
    logic                    r_wall, n_wall;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_any, n_any;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic [COL_W-1:0]        r_k, n_k;

    logic                    w_merge;
    logic                    w_lead;
    logic [CNT_W-1:0]        w_nm1;
    logic [PICK_W+COL_W-1:0] w_prod;

    assign w_merge = (r_lab != i_right_lab) && (i_ctl.last || r_jb);
    assign w_lead  = i_bus.act && (i_bus.lab == i_col);
    assign w_nm1   = r_cnt - CNT_W'(1);
    assign w_prod  = {{COL_W{1'b0}}, i_ctl.pick} * {{PICK_W{1'b0}}, w_nm1[COL_W-1:0]};

    assign o_tok  = r_tok;
    assign o_lab  = r_lab;
    assign o_wall = r_wall;
    assign o_open = r_opn;
    assign o_hit  = (i_ctl.st == ST_PICK) && w_lead && !r_any && (r_seen == {1'b0, r_k});

    always_comb begin
        o_bus = '0;
        if (r_tok && i_use) begin
            o_bus.act = 1'b1;
            o_bus.idx = i_col;
            o_bus.opn = r_opn;
            o_bus.lab = r_lab;
            case (i_ctl.st)
                ST_LOAD: begin
                    o_bus.car = r_rcar;
                    o_bus.lab = r_raw;
                end
                ST_JOIN: begin
                    o_bus.merge = w_merge;
                    o_bus.lo    = (r_lab < i_right_lab) ? r_lab : i_right_lab;
                    o_bus.hi    = (r_lab < i_right_lab) ? i_right_lab : r_lab;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_lab  = r_lab;
        n_car  = r_car;
        n_raw  = r_raw;
        n_rcar = r_rcar;
        n_asg  = r_asg;
        n_jb   = r_jb;
        n_opn  = r_opn;
        n_wall = r_wall;
        n_cnt  = r_cnt;
        n_any  = r_any;
        n_seen = r_seen;
        n_k    = r_k;
        if (i_ctl.init) begin
            n_raw  = r_lab;
            n_rcar = !i_ctl.in_first && r_car;
            n_asg  = 1'b0;
            n_jb   = i_jbit;
            n_opn  = !i_ctl.in_last && i_obit;
            n_wall = 1'b1;
            n_cnt  = '0;
            n_any  = 1'b0;
            n_seen = '0;
        end
        case (i_ctl.st)
            ST_LOAD: begin
                // first carried column of a set names it, fresh columns name themselves
                if (i_use && !r_asg &&
                    (r_tok || (r_rcar && i_bus.car && (r_raw == i_bus.lab)))) begin
                    n_lab = i_bus.idx;
                    n_asg = 1'b1;
                end
            end
            ST_JOIN: begin
                if (i_bus.merge && (r_lab == i_bus.hi)) n_lab = i_bus.lo;
                if (r_tok) n_wall = !w_merge;
            end
            ST_COUNT: begin
                if (w_lead) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    n_any = r_any | i_bus.opn;
                end
            end
            ST_KCALC: n_k = w_prod[PICK_W +: COL_W];
            ST_PICK: begin
                if (w_lead) n_seen = r_seen + CNT_W'(1);
                if (r_tok && i_hit) n_opn = 1'b1;
            end
            ST_DONE: begin
                if (i_ctl.commit) begin
                    n_car = i_use && r_opn;
                    n_lab = i_use ? r_lab : i_col;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_lab <= i_col;
            r_car <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_lab <= n_lab;
            r_car <= n_car;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw  <= n_raw;
        r_rcar <= n_rcar;
        r_asg  <= n_asg;
        r_jb   <= n_jb;
        r_opn  <= n_opn;
        r_wall <= n_wall;
        r_cnt  <= n_cnt;
        r_any  <= n_any;
        r_seen <= n_seen;
        r_k    <= n_k;
    end

endmodule

FILE: sv/eller_maze_row_generator.sv
// Eller maze row generator: each transfer on the input stream produces one maze row on the
// output stream, a right-wall mask and a top-wall mask. The row is held in a chain of
// MAX_COLUMNS cells, one per column, each keeping its set label (always the leftmost column
// of its set) and whether the row below continues it. A token walks the chain one cell per
// cycle, once for each phase: label load, boundary joins, set sizing, forced openings. A
// last row skips the sizing and opening sweeps. The input is ready again in the cycle the
// result turns valid; a new row is taken only once the previous one has been written to
// the output register. A result still waiting downstream lets the next row run its sweeps
// and only holds it at the final write to the output register. The width register
// (columns_in_use, clamped to 2..MAX_COLUMNS) is to be written by the user between rows;
// the block does not enforce this. Columns beyond it return zero wall bits and fall back
// to their reset state.
module eller_maze_row_generator
    import emr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: columns_in_use
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    // row requests
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,   // join_bits[14:0], open_bits[30:15], pick_fraction[38:31], zero pad
    input  logic             s_axis_tuser,   // first_row
    input  logic             s_axis_tlast,   // last_row
    // row results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata    // right_walls[14:0], top_walls[30:15], zero pad
);

    localparam int OPEN_LSB = JOIN_W;
    localparam int PICK_LSB = JOIN_W + MAX_COLUMNS;

    // sequencer and configuration
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_step, n_step;
    logic [CFG_W-1:0]    r_cols;
    logic [CNT_W-1:0]    r_w;
    logic                r_last;
    logic [PICK_W-1:0]   r_pick;

    // output register
    logic                r_ov;
    logic [JOIN_W-1:0]   r_right;
    logic [MAX_COLUMNS-1:0] r_top;

    logic                w_accept;
    logic                w_start;
    logic                w_commit;
    t_ctl                w_ctl;
    t_bus                w_bus;
    logic                w_hit;
    logic [MAX_COLUMNS-1:0] w_use;
    logic [MAX_COLUMNS-1:0] w_jbits;
    logic [MAX_COLUMNS-1:0] w_tok_in;
    logic [MAX_COLUMNS-1:0] w_tok;
    logic [MAX_COLUMNS-1:0] w_wall;
    logic [MAX_COLUMNS-1:0] w_open;
    logic [MAX_COLUMNS-1:0] w_cell_hit;
    logic [COL_W-1:0]    w_lab   [MAX_COLUMNS];
    logic [COL_W-1:0]    w_rlab  [MAX_COLUMNS];
    t_bus                w_cbus  [MAX_COLUMNS];
    logic [JOIN_W-1:0]   w_right;
    logic [MAX_COLUMNS-1:0] w_top;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == ST_DONE) && (!r_ov || m_axis_tready);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_top, r_right};

    // the last column has no right neighbor to join with
    assign w_jbits = {1'b0, s_axis_tdata[JOIN_W-1:0]};

    always_comb begin
        for (int x = 0; x < MAX_COLUMNS; x++) begin
            w_use[x] = (CNT_W'(x) < r_w);
        end
    end

    // phase sequencing: each sweep steps through the used columns from column 0 upward
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_LOAD;
            ST_LOAD:  if (r_step == r_w - CNT_W'(1)) n_state = ST_JOIN;
            ST_JOIN:  if (r_step == r_w - CNT_W'(2)) n_state = r_last ? ST_DONE : ST_COUNT;
            ST_COUNT: if (r_step == r_w - CNT_W'(1)) n_state = ST_KCALC;
            ST_KCALC: n_state = ST_PICK;
            ST_PICK:  if (r_step == r_w - CNT_W'(1)) n_state = ST_DONE;
            ST_DONE:  if (w_commit) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
        n_step  = (n_state == r_state) ? r_step + CNT_W'(1) : '0;
        // a new sweep drops its token into column 0
        w_start = (n_state != r_state) &&
                  ((n_state == ST_LOAD) || (n_state == ST_JOIN) ||
                   (n_state == ST_COUNT) || (n_state == ST_PICK));
    end

    always_comb begin
        w_ctl          = '0;
        w_ctl.st       = r_state;
        w_ctl.init     = w_accept;
        w_ctl.commit   = w_commit;
        w_ctl.in_first = s_axis_tuser;
        w_ctl.in_last  = s_axis_tlast;
        w_ctl.last     = r_last;
        w_ctl.pick     = r_pick;
    end

    // token hand-off: stale tokens are flushed when the phase changes
    always_comb begin
        w_tok_in[0] = w_start;
        for (int x = 1; x < MAX_COLUMNS; x++) begin
            w_tok_in[x] = (n_state == r_state) && w_tok[x-1];
        end
    end

    always_comb begin
        for (int x = 0; x < MAX_COLUMNS - 1; x++) begin
            w_rlab[x] = w_lab[x+1];
        end
        w_rlab[MAX_COLUMNS-1] = '0;
    end

    // only the token cell drives the bus, so an or-merge is enough
    always_comb begin
        w_bus = '0;
        for (int x = 0; x < MAX_COLUMNS; x++) begin
            w_bus = t_bus'(w_bus | w_cbus[x]);
        end
        w_hit = |w_cell_hit;
    end

    for (genvar x = 0; x < MAX_COLUMNS; x++) begin : g_cell
        emr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_col       (COL_W'(x)),
            .i_use       (w_use[x]),
            .i_ctl       (w_ctl),
            .i_jbit      (w_jbits[x]),
            .i_obit      (s_axis_tdata[OPEN_LSB + x]),
            .i_tok       (w_tok_in[x]),
            .o_tok       (w_tok[x]),
            .i_right_lab (w_rlab[x]),
            .o_lab       (w_lab[x]),
            .i_bus       (w_bus),
            .o_bus       (w_cbus[x]),
            .i_hit       (w_hit),
            .o_hit       (w_cell_hit[x]),
            .o_wall      (w_wall[x]),
            .o_open      (w_open[x])
        );
    end

    // wall masks: the right bit of the last used column and all unused columns read 0
    always_comb begin
        for (int x = 0; x < JOIN_W; x++) begin
            w_right[x] = w_use[x+1] && w_wall[x];
        end
        for (int x = 0; x < MAX_COLUMNS; x++) begin
            w_top[x] = w_use[x] && !w_open[x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_cols  <= CFG_W'(MAX_COLUMNS);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_valid && o_cfg_ready) r_cols <= i_cfg_data;
            if (w_commit) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= s_axis_tlast;
            r_pick <= s_axis_tdata[PICK_LSB +: PICK_W];
            if (r_cols < CFG_W'(2)) r_w <= CNT_W'(2);
            else if (r_cols > CFG_W'(MAX_COLUMNS)) r_w <= CNT_W'(MAX_COLUMNS);
            else r_w <= CNT_W'(r_cols);
        end
        if (w_commit) begin
            r_right <= w_right;
            r_top   <= w_top;
        end
    end

endmodule

FILE: sv/emr_checker.sv
module emr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [31:0]      m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a row is worked on before the next one is taken
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a row is in progress");

    // a new result only appears at the end of a row's work
    a_result_from_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a row in progress");

    // no result right out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind eller_maze_row_generator emr_checker u_emr_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench
    import emr_pkg::*;
();

    localparam int HALF_PERIOD  = 4;
    localparam int GAP_MAX      = 12;
    localparam int ROW_SETTLE   = 4 * MAX_COLUMNS + 16;  // one full row at the widest setting
    localparam int HOLD_CYCLES  = 400;                   // long enough for the block to back up
    localparam int RANDOM_ROWS  = 1880;
    localparam int CYCLE_LIMIT  = 1000000;

    // one maze row as the output stream carries it
    typedef struct packed {
        logic [JOIN_W-1:0]      right;
        logic [MAX_COLUMNS-1:0] top;
    } t_row_walls;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [39:0]            s_axis_tdata = '0;   // join_bits, open_bits, pick_fraction, pad
    logic                   s_axis_tuser = 1'b0; // first_row
    logic                   s_axis_tlast = 1'b0; // last_row
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;        // right_walls, top_walls, pad

    // maze state as the block should hold it
    logic [COL_W-1:0]       col_label [MAX_COLUMNS];
    bit                     col_carried [MAX_COLUMNS];
    logic [CFG_W-1:0]       width_shadow;

    t_row_walls             pending_walls [$];
    int                     fail_count = 0;
    int                     cycle_count = 0;
    bit                     quiet_tx = 1'b0;
    bit                     quiet_rx = 1'b0;
    int                     rx_gap = 0;
    int                     hold_left = 0;
    logic                   hold_kick = 1'b0;

    eller_maze_row_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // computes the walls of one row and advances the maze state
    function automatic t_row_walls build_row(input bit first, input bit last,
                                             input logic [JOIN_W-1:0] jb,
                                             input logic [MAX_COLUMNS-1:0] ob,
                                             input logic [PICK_W-1:0] pick);
        t_row_walls walls;
        int w, n, k, seen, lo, hi;
        int raw [MAX_COLUMNS];
        int lab [MAX_COLUMNS];
        bit opened [MAX_COLUMNS];
        bit any_open;
        walls = '0;
        w = int'(width_shadow);
        if (w < 2) w = 2;
        if (w > MAX_COLUMNS) w = MAX_COLUMNS;

        // load: carried cells keep their set, the others get a set of their own
        for (int x = 0; x < w; x++) begin
            raw[x] = (!first && col_carried[x]) ? int'(col_label[x]) : x + MAX_COLUMNS;
            opened[x] = 1'b0;
        end
        for (int x = 0; x < w; x++) begin
            lab[x] = x;
            for (int y = x - 1; y >= 0; y--)
                if (raw[y] == raw[x]) lab[x] = y;
        end

        // join left to right, merged set keeps the smaller label
        for (int x = 0; x + 1 < w; x++) begin
            if (lab[x] != lab[x + 1] && (last || jb[x])) begin
                lo = (lab[x] < lab[x + 1]) ? lab[x] : lab[x + 1];
                hi = (lab[x] < lab[x + 1]) ? lab[x + 1] : lab[x];
                for (int y = 0; y < w; y++)
                    if (lab[y] == hi) lab[y] = lo;
            end else begin
                walls.right[x] = 1'b1;
            end
        end

        // every set opens downward at least once, except on the last row
        if (!last) begin
            for (int x = 0; x < w; x++) begin
                if (lab[x] == x) begin
                    n = 0;
                    any_open = 1'b0;
                    for (int y = x; y < w; y++) begin
                        if (lab[y] == x) begin
                            n++;
                            if (ob[y]) begin
                                opened[y] = 1'b1;
                                any_open = 1'b1;
                            end
                        end
                    end
                    if (!any_open) begin
                        k = (int'(pick) * (n - 1)) >> 8;
                        seen = 0;
                        for (int y = x; y < w; y++) begin
                            if (lab[y] == x) begin
                                if (seen == k) opened[y] = 1'b1;
                                seen++;
                            end
                        end
                    end
                end
            end
        end

        for (int x = 0; x < MAX_COLUMNS; x++) begin
            if (x < w) begin
                walls.top[x] = !opened[x];
                col_label[x] = lab[x][COL_W-1:0];
                col_carried[x] = opened[x];
            end else begin
                col_label[x] = x[COL_W-1:0];
                col_carried[x] = 1'b0;
            end
        end
        return walls;
    endfunction

    // offers one row request and records its walls once the transfer happens
    task automatic send_row(input bit first, input bit last, input logic [JOIN_W-1:0] jb,
                            input logic [MAX_COLUMNS-1:0] ob, input logic [PICK_W-1:0] pick);
        int gap;
        t_row_walls walls;
        gap = quiet_tx ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, pick, ob, jb};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        walls = build_row(first, last, jb, ob, pick);
        pending_walls.insert(pending_walls.size(), walls);
    endtask

    task automatic send_random_row(input bit first, input bit last);
        logic [JOIN_W-1:0]      jb;
        logic [MAX_COLUMNS-1:0] ob;
        // sparse open bits make the forced openings do most of the work
        case ($urandom_range(0, 3))
            0:       ob = 16'($urandom);
            1:       ob = 16'($urandom & $urandom);
            2:       ob = 16'($urandom & $urandom & $urandom);
            default: ob = '0;
        endcase
        jb = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom | $urandom);
        send_row(first, last, jb, ob, 8'($urandom_range(0, 255)));
    endtask

    // lets every row come out and the block go idle
    task automatic drain_rows();
        s_axis_tvalid <= 1'b0;
        while (pending_walls.size() != 0) @(posedge i_clk);
        repeat (ROW_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] value);
        drain_rows();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        width_shadow = value;
    endtask

    // reset width: fresh rows, full joins, forced openings at both pick extremes
    task automatic test_full_width();
        send_row(1'b1, 1'b0, '0, '0, 8'h00);
        send_row(1'b0, 1'b0, '1, '0, 8'hFF);
        send_row(1'b0, 1'b0, '0, '1, 8'h80);
        send_row(1'b0, 1'b0, 15'h5555, 16'hAAAA, 8'h80);
        send_row(1'b0, 1'b1, '0, '0, 8'h00);
        // nothing carried after a last row, so this one starts fresh
        send_row(1'b0, 1'b0, 15'h2AAA, 16'h5555, 8'hFF);
        send_row(1'b1, 1'b1, '0, '1, 8'hFF);
        send_row(1'b1, 1'b0, 15'h7F00, '0, 8'hC0);
        send_row(1'b0, 1'b0, 15'h00FF, '0, 8'h40);
        send_row(1'b0, 1'b0, '1, '0, 8'hFF);
    endtask

    // widths below the minimum, the minimum and above the maximum
    task automatic test_width_clamp();
        logic [CFG_W-1:0] widths [4] = '{5'd0, 5'd2, 5'd31, 5'd1};
        foreach (widths[i]) begin
            write_width(widths[i]);
            send_row(1'b1, 1'b0, '1, '1, 8'hFF);
            send_row(1'b0, 1'b0, '0, '0, 8'hFF);
            send_row(1'b0, 1'b1, '0, '0, 8'h00);
        end
    endtask

    // receiver stalls for a long stretch while rows keep coming back to back
    task automatic test_output_stall();
        write_width(5'd16);
        quiet_tx = 1'b1;
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
        for (int r = 0; r < 12; r++)
            send_random_row(r == 0, r == 11);
        quiet_tx = 1'b0;
    endtask

    // whole mazes of random length, with some rows of random flags between them
    task automatic test_random_mazes();
        int sent, rows;
        sent = 0;
        while (sent < RANDOM_ROWS) begin
            write_width(($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 31)));
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10)) begin
                rows = $urandom_range(1, 12);
                if ($urandom_range(0, 4) == 0) begin
                    repeat (rows)
                        send_random_row($urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
                end else begin
                    for (int r = 0; r < rows; r++)
                        send_random_row(r == 0, r == rows - 1);
                end
                sent += rows;
            end
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // long receiver hold, counted on its own
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // receiver: checks each transfer against the oldest expected row, then draws its stall
    always @(posedge i_clk) begin : rx_side
        t_row_walls want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_walls.size() == 0) begin
                    $display("%0t: row with no request pending, actual %h", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_walls.pop_front();
                    if (m_axis_tdata[14:0] !== want.right) begin
                        $display("%0t: right_walls expected %h actual %h",
                                 $time, want.right, m_axis_tdata[14:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[30:15] !== want.top) begin
                        $display("%0t: top_walls expected %h actual %h",
                                 $time, want.top, m_axis_tdata[30:15]);
                        fail_count++;
                    end
                end
                rx_gap = quiet_rx ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d rows outstanding", $time, pending_walls.size());
            $display("eller_maze_row_generator test failed");
            $finish;
        end
    end

    initial begin
        width_shadow = 5'd16;
        for (int x = 0; x < MAX_COLUMNS; x++) begin
            col_label[x] = x[COL_W-1:0];
            col_carried[x] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_width();
        test_width_clamp();
        test_output_stall();
        test_random_mazes();
        drain_rows();

        if (fail_count == 0) begin
            $display("eller_maze_row_generator test passed");
        end else begin
            $display("eller_maze_row_generator test failed");
        end
        $finish;
    end

endmodule
